### hw/rtl/drwd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the differential RMS window detector.
// Depends on nothing; every other file but drwd_in_if refers to it by scoped names.
package drwd_pkg;

    // Fixed field widths.
    localparam int WLOG_W     = 4;
    localparam int THR_W      = 12;
    localparam int MS_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register values after reset.
    localparam logic [WLOG_W-1:0] WLOG_RST      = 4'd9;
    localparam logic [THR_W-1:0]  BEGIN_THR_RST = 12'd4095;
    localparam logic [THR_W-1:0]  CUT_THR_RST   = 12'd2667;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOG2 = 2'd0,
        CFG_BEGIN_THR   = 2'd1,
        CFG_CUT_THR     = 2'd2
    } t_cfg_idx;

    // Mode flags that travel with a word down the pipeline.
    typedef struct packed {
        logic arc_detected;
        logic measure_begun;
    } t_flags;

endpackage

### hw/rtl/drwd_in_if.sv
`timescale 1ns / 1ps
// Input channel of the detector: one word carries three ADC samples and two flags.
// Depends on nothing.
interface drwd_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_line;
    logic [SAMPLE_BITS-1:0] sample_reference;
    logic [SAMPLE_BITS-1:0] sample_current;
    logic                   arc_detected;
    logic                   measure_begun;

    modport source (
        output valid, sample_line, sample_reference, sample_current,
               arc_detected, measure_begun,
        input  ready
    );
    modport sink (
        input  valid, sample_line, sample_reference, sample_current,
               arc_detected, measure_begun,
        output ready
    );
endinterface

### hw/rtl/drwd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the detector: one word per closed window.
// Depends on drwd_pkg for the field widths.
interface drwd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         begin_detected;
    logic                         open_detected;
    logic [drwd_pkg::MS_W-1:0]    voltage_mean_square;
    logic [drwd_pkg::MS_W-1:0]    current_mean_square;

    modport source (
        output valid, begin_detected, open_detected, voltage_mean_square,
               current_mean_square,
        input  ready
    );
    modport sink (
        input  valid, begin_detected, open_detected, voltage_mean_square,
               current_mean_square,
        output ready
    );
endinterface

### hw/rtl/drwd_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on drwd_pkg for the field widths.
interface drwd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [drwd_pkg::CFG_IDX_W-1:0]   index;
    logic [drwd_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hw/rtl/drwd_square.sv
`timescale 1ns / 1ps
// Input register and squaring stage: absolute differences and their squares.
// Depends on drwd_pkg and drwd_in_if.
module drwd_square #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    drwd_in_if.sink                    i_in,
    output logic                       o_sq_valid,
    input  logic                       i_sq_ready,
    output logic [2*SAMPLE_BITS-1:0]   o_sq_v,
    output logic [2*SAMPLE_BITS-1:0]   o_sq_c,
    output drwd_pkg::t_flags           o_flags
);
    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                   r_v1;
    logic [SAMPLE_BITS-1:0] r_line;
    logic [SAMPLE_BITS-1:0] r_ref;
    logic [SAMPLE_BITS-1:0] r_cur;
    drwd_pkg::t_flags       r_flags1;

    logic                   r_v2;
    logic [SQ_W-1:0]        r_sq_v;
    logic [SQ_W-1:0]        r_sq_c;
    drwd_pkg::t_flags       r_flags2;

    logic                   w_adv1;
    logic                   w_adv2;
    logic [SAMPLE_BITS-1:0] w_dv;
    logic [SAMPLE_BITS-1:0] w_dc;
    logic [SQ_W-1:0]        n_sq_v;
    logic [SQ_W-1:0]        n_sq_c;

    // Each stage moves when it is empty or the next one moves.
    assign w_adv2     = !r_v2 || i_sq_ready;
    assign w_adv1     = !r_v1 || w_adv2;
    assign i_in.ready = w_adv1;

    always_comb begin
        w_dv   = (r_line >= r_ref) ? (r_line - r_ref) : (r_ref - r_line);
        w_dc   = (r_cur >= r_ref) ? (r_cur - r_ref) : (r_ref - r_cur);
        n_sq_v = SQ_W'(w_dv) * SQ_W'(w_dv);
        n_sq_c = SQ_W'(w_dc) * SQ_W'(w_dc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_in.valid) begin
            r_line                 <= i_in.sample_line;
            r_ref                  <= i_in.sample_reference;
            r_cur                  <= i_in.sample_current;
            r_flags1.arc_detected  <= i_in.arc_detected;
            r_flags1.measure_begun <= i_in.measure_begun;
        end
        if (w_adv2 && r_v1) begin
            r_sq_v   <= n_sq_v;
            r_sq_c   <= n_sq_c;
            r_flags2 <= r_flags1;
        end
    end

    assign o_sq_valid = r_v2;
    assign o_sq_v     = r_sq_v;
    assign o_sq_c     = r_sq_c;
    assign o_flags    = r_flags2;

endmodule

### hw/rtl/drwd_accum.sv
`timescale 1ns / 1ps
// Window accumulator: gated square sums, sample counter and held mean squares.
// Depends on drwd_pkg.
module drwd_accum #(
    parameter int MAX_WINDOW_LOG2 = 10,
    parameter int SAMPLE_BITS     = 12
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [drwd_pkg::WLOG_W-1:0]                  i_window_log2,
    input  logic                                         i_sq_valid,
    output logic                                         o_sq_ready,
    input  logic [2*SAMPLE_BITS-1:0]                     i_sq_v,
    input  logic [2*SAMPLE_BITS-1:0]                     i_sq_c,
    input  drwd_pkg::t_flags                             i_flags,
    output logic                                         o_close_valid,
    input  logic                                         i_close_ready,
    output logic [2*SAMPLE_BITS+MAX_WINDOW_LOG2-1:0]     o_held_v,
    output logic [2*SAMPLE_BITS+MAX_WINDOW_LOG2-1:0]     o_held_c
);
    localparam int SUM_W = 2 * SAMPLE_BITS + MAX_WINDOW_LOG2;
    localparam int CNT_W = MAX_WINDOW_LOG2;
    localparam int LG_W  = $clog2(MAX_WINDOW_LOG2 + 1);
    localparam int WL_W  = (LG_W > drwd_pkg::WLOG_W) ? LG_W : drwd_pkg::WLOG_W;

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum_v;
    logic [SUM_W-1:0] r_sum_c;
    logic [SUM_W-1:0] r_held_v;
    logic [SUM_W-1:0] r_held_c;
    logic             r_en_v;
    logic             r_en_c;
    logic             r_close;

    logic             w_take;
    logic [WL_W-1:0]  w_wlog;
    logic [WL_W-1:0]  w_lg_sat;
    logic [LG_W-1:0]  w_lg;
    logic [CNT_W-1:0] w_last;
    logic             w_first;
    logic             w_close;
    logic             n_en_v;
    logic             n_en_c;
    logic [SUM_W-1:0] n_sum_v;
    logic [SUM_W-1:0] n_sum_c;

    assign o_sq_ready = !r_close || i_close_ready;
    assign w_take     = i_sq_valid && o_sq_ready;

    always_comb begin
        // Oversized window settings saturate at the largest supported window.
        w_wlog   = WL_W'(i_window_log2);
        w_lg_sat = (w_wlog > WL_W'(MAX_WINDOW_LOG2)) ? WL_W'(MAX_WINDOW_LOG2) : w_wlog;
        w_lg     = LG_W'(w_lg_sat);
        w_last   = ~({CNT_W{1'b1}} << w_lg);
        // A window also closes when it was shrunk below the current count.
        w_close  = (r_count >= w_last);
        w_first  = (r_count == '0);
        n_en_v   = w_first ? (!i_flags.measure_begun || i_flags.arc_detected) : r_en_v;
        n_en_c   = w_first ? !i_flags.arc_detected : r_en_c;
        n_sum_v  = r_sum_v + (n_en_v ? SUM_W'(i_sq_v) : '0);
        n_sum_c  = r_sum_c + (n_en_c ? SUM_W'(i_sq_c) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum_v  <= '0;
            r_sum_c  <= '0;
            r_held_v <= '0;
            r_held_c <= '0;
            r_en_v   <= 1'b0;
            r_en_c   <= 1'b0;
            r_close  <= 1'b0;
        end else begin
            // A new closing word sets the flag; otherwise it clears once taken.
            if (w_take && w_close) begin
                r_close <= 1'b1;
            end else if (i_close_ready) begin
                r_close <= 1'b0;
            end
            if (w_take) begin
                r_en_v <= n_en_v;
                r_en_c <= n_en_c;
                if (w_close) begin
                    if (n_en_v) begin
                        r_held_v <= n_sum_v >> w_lg;
                    end
                    if (n_en_c) begin
                        r_held_c <= n_sum_c >> w_lg;
                    end
                    r_sum_v <= '0;
                    r_sum_c <= '0;
                    r_count <= '0;
                end else begin
                    r_sum_v <= n_sum_v;
                    r_sum_c <= n_sum_c;
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    assign o_close_valid = r_close;
    assign o_held_v      = r_held_v;
    assign o_held_c      = r_held_c;

endmodule

### hw/rtl/drwd_decide.sv
`timescale 1ns / 1ps
// Threshold decisions and the output register of the result channel.
// Depends on drwd_pkg and drwd_out_if.
module drwd_decide #(
    parameter int SUM_W = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_close_valid,
    output logic                          o_close_ready,
    input  logic [SUM_W-1:0]              i_held_v,
    input  logic [SUM_W-1:0]              i_held_c,
    input  logic [drwd_pkg::MS_W-1:0]     i_begin_sq,
    input  logic [drwd_pkg::MS_W-1:0]     i_cut_sq,
    drwd_out_if.source                    o_out
);
    localparam int CMP_W = (SUM_W > drwd_pkg::MS_W) ? SUM_W : drwd_pkg::MS_W;

    logic                      r_valid;
    logic                      r_begin;
    logic                      r_open;
    logic [drwd_pkg::MS_W-1:0] r_vms;
    logic [drwd_pkg::MS_W-1:0] r_cms;

    logic [CMP_W-1:0]          w_v;
    logic [CMP_W-1:0]          w_c;
    logic                      w_load;

    assign o_close_ready = !r_valid || o_out.ready;
    assign w_load        = i_close_valid && o_close_ready;
    assign w_v           = CMP_W'(i_held_v);
    assign w_c           = CMP_W'(i_held_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_close_ready) begin
            r_valid <= i_close_valid;
        end
    end

    // Decisions use the full mean square; the fields carry its low bits.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_begin <= (w_v > CMP_W'(i_begin_sq));
            r_open  <= (w_v < CMP_W'(i_cut_sq));
            r_vms   <= w_v[drwd_pkg::MS_W-1:0];
            r_cms   <= w_c[drwd_pkg::MS_W-1:0];
        end
    end

    assign o_out.valid               = r_valid;
    assign o_out.begin_detected      = r_begin;
    assign o_out.open_detected       = r_open;
    assign o_out.voltage_mean_square = r_vms;
    assign o_out.current_mean_square = r_cms;

endmodule

### hw/rtl/differential_rms_window_detector_top.sv
`timescale 1ns / 1ps
// Top level of the differential RMS window detector: configuration registers and stages.
// Depends on drwd_pkg, the three channel interfaces, drwd_square, drwd_accum, drwd_decide.

// The detector takes one word per clock cycle unless stalled, each holding a line, a
// reference and a current ADC sample plus the arc and measure flags. It squares the
// line-minus-reference and current-minus-reference differences and sums them over a
// window of 2^window_log2 words (window_log2 saturates at MAX_WINDOW_LOG2). The word that
// closes a window yields one result word: the two mean squares (sums shifted right,
// truncating) and the begin and open decisions, which compare the voltage mean square
// against the squared thresholds. The flags of the first word of a window gate the
// channels for the whole window; a gated channel reports the mean square of its last
// enabled window. The sustained rate is one input word per cycle unless stalled, set by
// the single accumulate-and-count step of the window adder. After the closing word is
// accepted, its result passes the input register, squaring multiplier, accumulator and
// output register. Words keep flowing while a result waits on the output, until the
// next closing word reaches the accumulator. Configuration writes are always ready; the
// window size takes effect on the following cycle, the squared thresholds after their
// squaring register. They are meant to be made while no word is in flight.
module differential_rms_window_detector_top #(
    parameter int MAX_WINDOW_LOG2 = 10,
    parameter int SAMPLE_BITS     = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    drwd_cfg_if.sink               i_cfg,
    drwd_in_if.sink                i_in,
    drwd_out_if.source             o_out
);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = SQ_W + MAX_WINDOW_LOG2;

    // Configuration registers.
    logic [drwd_pkg::WLOG_W-1:0] r_window_log2;
    logic [drwd_pkg::THR_W-1:0]  r_begin_thr;
    logic [drwd_pkg::THR_W-1:0]  r_cut_thr;

    // Squared thresholds, recomputed every cycle so the compare path holds no multiplier.
    logic [drwd_pkg::MS_W-1:0]   r_begin_sq;
    logic [drwd_pkg::MS_W-1:0]   r_cut_sq;

    logic                        w_sq_valid;
    logic                        w_sq_ready;
    logic [SQ_W-1:0]             w_sq_v;
    logic [SQ_W-1:0]             w_sq_c;
    drwd_pkg::t_flags            w_flags;
    logic                        w_close_valid;
    logic                        w_close_ready;
    logic [SUM_W-1:0]            w_held_v;
    logic [SUM_W-1:0]            w_held_c;

    assign i_cfg.ready = 1'b1;

    // A write to an index beyond the register list is accepted and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_log2 <= drwd_pkg::WLOG_RST;
            r_begin_thr   <= drwd_pkg::BEGIN_THR_RST;
            r_cut_thr     <= drwd_pkg::CUT_THR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                drwd_pkg::CFG_WINDOW_LOG2: begin
                    r_window_log2 <= i_cfg.data[drwd_pkg::WLOG_W-1:0];
                end
                drwd_pkg::CFG_BEGIN_THR: begin
                    r_begin_thr <= i_cfg.data[drwd_pkg::THR_W-1:0];
                end
                drwd_pkg::CFG_CUT_THR: begin
                    r_cut_thr <= i_cfg.data[drwd_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_begin_sq <= {{(drwd_pkg::MS_W - drwd_pkg::THR_W){1'b0}}, r_begin_thr}
                    * {{(drwd_pkg::MS_W - drwd_pkg::THR_W){1'b0}}, r_begin_thr};
        r_cut_sq   <= {{(drwd_pkg::MS_W - drwd_pkg::THR_W){1'b0}}, r_cut_thr}
                    * {{(drwd_pkg::MS_W - drwd_pkg::THR_W){1'b0}}, r_cut_thr};
    end

    drwd_square #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_square (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_sq_valid (w_sq_valid),
        .i_sq_ready (w_sq_ready),
        .o_sq_v     (w_sq_v),
        .o_sq_c     (w_sq_c),
        .o_flags    (w_flags)
    );

    drwd_accum #(
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_log2 (r_window_log2),
        .i_sq_valid    (w_sq_valid),
        .o_sq_ready    (w_sq_ready),
        .i_sq_v        (w_sq_v),
        .i_sq_c        (w_sq_c),
        .i_flags       (w_flags),
        .o_close_valid (w_close_valid),
        .i_close_ready (w_close_ready),
        .o_held_v      (w_held_v),
        .o_held_c      (w_held_c)
    );

    drwd_decide #(
        .SUM_W (SUM_W)
    ) u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_close_valid (w_close_valid),
        .o_close_ready (w_close_ready),
        .i_held_v      (w_held_v),
        .i_held_c      (w_held_c),
        .i_begin_sq    (r_begin_sq),
        .i_cut_sq      (r_cut_sq),
        .o_out         (o_out)
    );

    // The input side can only stall when the squaring stage holds a word.
    a_in_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_sq_valid)
        else $error("input stalled with an empty squaring stage");

    // A closed window that the output stage cannot take stays pending.
    a_close_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_close_valid && !w_close_ready) |=> w_close_valid)
        else $error("pending window result dropped");

    // A new result word only comes from a closed window.
    a_out_from_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_close_valid))
        else $error("result word without a closed window");

endmodule
